### rtl/core/vehicle_mode_supervisor_macros.svh
// Assertion helpers shared by the supervisor files.
// All checks sample on clk and are switched off while rst is high.
`ifndef VEHICLE_MODE_SUPERVISOR_MACROS_SVH
`define VEHICLE_MODE_SUPERVISOR_MACROS_SVH

// Same-cycle implication.
`define VMS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VMS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/vms_pkg.sv
`default_nettype none
package vms_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int SUM_W = ((TIMER_WIDTH > 16) ? TIMER_WIDTH : 16) + 1;

  localparam int IN_W  = 48;
  localparam int OUT_W = 16;

  // Modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_DRIVE = 3'd1;
  localparam logic [2:0] MODE_LIFT  = 3'd2;
  localparam logic [2:0] MODE_DUMP  = 3'd3;
  localparam logic [2:0] MODE_FAULT = 3'd4;
  localparam logic [2:0] MODE_ESTOP = 3'd5;

  // Fault causes
  localparam logic [3:0] CAUSE_NONE       = 4'd0;
  localparam logic [3:0] CAUSE_ESTOP      = 4'd1;
  localparam logic [3:0] CAUSE_DTC        = 4'd2;
  localparam logic [3:0] CAUSE_CAN        = 4'd3;
  localparam logic [3:0] CAUSE_COMMS      = 4'd4;
  localparam logic [3:0] CAUSE_LIFT_TMO   = 4'd5;
  localparam logic [3:0] CAUSE_LIFT_SENS  = 4'd6;
  localparam logic [3:0] CAUSE_DUMP_TMO   = 4'd7;
  localparam logic [3:0] CAUSE_DUMP_SENS  = 4'd8;

  // Register indexes
  localparam logic [1:0] REG_FAIL_LIMIT = 2'd0;
  localparam logic [1:0] REG_RECOVER    = 2'd1;
  localparam logic [1:0] REG_STOP_SPEED = 2'd2;

  localparam logic [15:0] FAIL_LIMIT_RST = 16'd500;
  localparam logic [15:0] RECOVER_RST    = 16'd1000;
  localparam logic [14:0] STOP_SPEED_RST = 15'd10;
  localparam logic [15:0] DT_DEFAULT     = 16'd10;

  // Packed MSB first, so the first field lands in the highest bits.
  typedef struct packed {
    logic [15:0]        elapsed_ms;
    logic signed [15:0] velocity;
    logic               ack_pressed;
    logic               causes_clear;
    logic [3:0]         work_signals;
    logic               batt_healthy;
    logic               drive_req;
    logic               link_ok;
    logic [5:0]         fault_inputs;
    logic               estop;
  } item_t;

  typedef struct packed {
    logic [3:0] pad;
    logic       comms_good;
    logic       fault_held;
    logic [3:0] fault_id;
    logic       tip_on;
    logic       hoist_on;
    logic       traction_on;
    logic [2:0] mode;
  } result_t;

  typedef struct packed {
    logic [15:0] comms_fail_limit_ms;
    logic [15:0] comms_recover_ms;
    logic [14:0] stop_speed_mm_s;
  } cfg_t;

  typedef struct packed {
    logic [TIMER_WIDTH-1:0] fail_time;
    logic [TIMER_WIDTH-1:0] good_time;
    logic                   comms_filtered;
  } comms_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       fault_latch;
    logic [3:0] latched_cause;
    logic       lift_inhibit;
    logic       dump_inhibit;
    comms_t     comms;
  } state_t;

endpackage
`default_nettype wire

### rtl/core/vehicle_mode_supervisor.sv
// Vehicle mode supervisor.
// One transfer on the slave stream (s_*) is one control tick; each tick
// produces exactly one result transfer on the master stream (m_*).
// Input tick and result are both registered: a tick accepted into the input
// register is evaluated against the supervisor state by combinational logic
// and its result is loaded into the result register when that register is
// free or draining, and is then offered on the master stream.
// Throughput is one tick per cycle while the receiver does not stall. The
// whole tick (comms filter, fault priority, mode transition) is shallow
// logic between the input register and the result register, and the state
// registers update in the same cycle as the result register.
// When the receiver stalls, the result register holds and the input
// register takes one more tick, after which s_tready drops until m_tready
// returns.
// Reset (rst, synchronous) empties both registers, returns the mode to
// idle, clears the fault latch, inhibits and timers, marks comms good and
// loads the configuration registers with their defaults.
// Configuration is written over the APB port; the user must write it only
// while no tick is in flight, as the block itself does not enforce this.
`default_nettype none
`include "vehicle_mode_supervisor_macros.svh"
module vehicle_mode_supervisor (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // s_tdata, from bit 0: estop, fault_inputs[5:0], link_ok, drive_req,
  // batt_healthy, work_signals[3:0], causes_clear, ack_pressed,
  // velocity[15:0] (signed), elapsed_ms[15:0]
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [vms_pkg::IN_W-1:0] s_tdata,
  // m_tdata, from bit 0: mode[2:0], traction_on, hoist_on, tip_on,
  // fault_id[3:0], fault_held, comms_good, four zero bits
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [vms_pkg::OUT_W-1:0]  m_tdata,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [3:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import vms_pkg::*;

  cfg_t    cfg;
  item_t   in_reg;
  logic    in_valid;
  result_t out_reg;
  logic    out_valid;
  state_t  st;
  state_t  st_next;
  comms_t  comms_next;
  result_t res;
  logic    adv;

  vms_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vms_comms_filter u_comms (
    .link_ok    (in_reg.link_ok),
    .elapsed_ms (in_reg.elapsed_ms),
    .cfg        (cfg),
    .cur        (st.comms),
    .nxt        (comms_next)
  );

  vms_mode_logic u_mode (
    .item      (in_reg),
    .cfg       (cfg),
    .cur       (st),
    .comms_nxt (comms_next),
    .nxt       (st_next),
    .res       (res)
  );

  // Advance the tick into the result register when it is free or draining.
  assign adv      = !out_valid || m_tready;
  assign s_tready = !in_valid || adv;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_reg <= item_t'(s_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      out_reg <= res;
    end
  end

  // Supervisor state moves on only when a tick is evaluated.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode                 <= MODE_IDLE;
      st.fault_latch          <= 1'b0;
      st.latched_cause        <= CAUSE_NONE;
      st.lift_inhibit         <= 1'b0;
      st.dump_inhibit         <= 1'b0;
      st.comms.fail_time      <= '0;
      st.comms.good_time      <= '0;
      st.comms.comms_filtered <= 1'b1;
    end else if (adv && in_valid) begin
      st <= st_next;
    end
  end

  // A latched fault always carries a real cause.
  `VMS_ASSERT_IMP(a_latch_has_cause, st.fault_latch, st.latched_cause != CAUSE_NONE, "latched fault without cause")
  // A reported fault code never comes with an actuator command.
  `VMS_ASSERT_IMP(a_code_quiet, m_tvalid && (out_reg.fault_id != CAUSE_NONE), !out_reg.traction_on && !out_reg.hoist_on && !out_reg.tip_on, "actuator commanded with a fault code")
  // At most one actuator is commanded, and traction only in drive.
  `VMS_ASSERT_IMP(a_one_cmd, m_tvalid, $onehot0({out_reg.traction_on, out_reg.hoist_on, out_reg.tip_on}) && (!out_reg.traction_on || (out_reg.mode == MODE_DRIVE)), "conflicting actuator commands")
  // Fault mode reported only with the latch held.
  `VMS_ASSERT_IMP(a_fault_held, m_tvalid && (out_reg.mode == MODE_FAULT), out_reg.fault_held, "fault mode without latch")

endmodule
`default_nettype wire

### rtl/core/vms_cfg_regs.sv
`default_nettype none
module vms_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output vms_pkg::cfg_t     cfg
);
  import vms_pkg::*;

  logic wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.comms_fail_limit_ms <= FAIL_LIMIT_RST;
      cfg.comms_recover_ms    <= RECOVER_RST;
      cfg.stop_speed_mm_s     <= STOP_SPEED_RST;
    end else if (wr) begin
      case (idx)
        REG_FAIL_LIMIT: cfg.comms_fail_limit_ms <= pwdata[15:0];
        REG_RECOVER:    cfg.comms_recover_ms    <= pwdata[15:0];
        REG_STOP_SPEED: cfg.stop_speed_mm_s     <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FAIL_LIMIT: prdata = {16'd0, cfg.comms_fail_limit_ms};
      REG_RECOVER:    prdata = {16'd0, cfg.comms_recover_ms};
      REG_STOP_SPEED: prdata = {17'd0, cfg.stop_speed_mm_s};
      default:        prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/vms_comms_filter.sv
`default_nettype none
module vms_comms_filter (
  input  wire logic          link_ok,
  input  wire logic [15:0]   elapsed_ms,
  input  wire vms_pkg::cfg_t cfg,
  input  wire vms_pkg::comms_t cur,
  output vms_pkg::comms_t    nxt
);
  import vms_pkg::*;

  localparam logic [SUM_W-1:0] TMAX =
    {{(SUM_W-TIMER_WIDTH){1'b0}}, {TIMER_WIDTH{1'b1}}};

  logic [15:0]      dt;
  logic [SUM_W-1:0] base;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sat;
  logic [SUM_W-1:0] limit;

  // A zero tick length stands for the default tick.
  assign dt   = (elapsed_ms == 16'd0) ? DT_DEFAULT : elapsed_ms;
  assign base = link_ok ? SUM_W'(cur.good_time) : SUM_W'(cur.fail_time);
  assign sum  = base + SUM_W'(dt);
  assign sat  = (sum > TMAX) ? TMAX : sum;
  assign limit = link_ok ? SUM_W'(cfg.comms_recover_ms) : SUM_W'(cfg.comms_fail_limit_ms);

  always_comb begin
    nxt = cur;
    if (!link_ok) begin
      nxt.fail_time = sat[TIMER_WIDTH-1:0];
      nxt.good_time = '0;
      if (sat >= limit) nxt.comms_filtered = 1'b0;
    end else begin
      nxt.good_time = sat[TIMER_WIDTH-1:0];
      nxt.fail_time = '0;
      if (sat >= limit) nxt.comms_filtered = 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/core/vms_mode_logic.sv
`default_nettype none
module vms_mode_logic (
  input  wire vms_pkg::item_t  item,
  input  wire vms_pkg::cfg_t   cfg,
  input  wire vms_pkg::state_t cur,
  input  wire vms_pkg::comms_t comms_nxt,
  output vms_pkg::state_t      nxt,
  output vms_pkg::result_t     res
);
  import vms_pkg::*;

  logic        lreq, ldone, dreq, ddone, den, bat, cgood;
  logic [15:0] vraw, mag;
  logic        stopped;
  logic [3:0]  cause;
  logic [2:0]  mode;
  logic        latch, lift_inh, dump_inh;
  logic [3:0]  lcause, code;
  logic        dcmd, lcmd, ucmd;

  assign lreq  = item.work_signals[0];
  assign ldone = item.work_signals[1];
  assign dreq  = item.work_signals[2];
  assign ddone = item.work_signals[3];
  assign den   = item.drive_req;
  assign bat   = item.batt_healthy;
  assign cgood = comms_nxt.comms_filtered;

  assign vraw    = item.velocity;
  assign mag     = vraw[15] ? (~vraw + 16'd1) : vraw;
  assign stopped = mag < {1'b0, cfg.stop_speed_mm_s};

  // Fixed priority, comms loss judged on this tick's filtered status.
  always_comb begin
    if (item.fault_inputs[0])      cause = CAUSE_DTC;
    else if (item.fault_inputs[1]) cause = CAUSE_CAN;
    else if (!cgood)               cause = CAUSE_COMMS;
    else if (item.fault_inputs[2]) cause = CAUSE_LIFT_TMO;
    else if (item.fault_inputs[3]) cause = CAUSE_LIFT_SENS;
    else if (item.fault_inputs[4]) cause = CAUSE_DUMP_TMO;
    else if (item.fault_inputs[5]) cause = CAUSE_DUMP_SENS;
    else                           cause = CAUSE_NONE;
  end

  always_comb begin
    lift_inh = cur.lift_inhibit && lreq;
    dump_inh = cur.dump_inhibit && dreq;
    latch    = cur.fault_latch;
    lcause   = cur.latched_cause;
    mode     = cur.mode;
    code     = CAUSE_NONE;
    dcmd     = 1'b0;
    lcmd     = 1'b0;
    ucmd     = 1'b0;
    if (item.estop) begin
      mode = MODE_ESTOP;
      code = CAUSE_ESTOP;
    end else begin
      if ((cause != CAUSE_NONE) && !latch) begin
        latch  = 1'b1;
        lcause = cause;
      end
      if (latch) mode = MODE_FAULT;
      case (mode)
        MODE_DRIVE: begin
          if (!den || !bat || !cgood) mode = MODE_IDLE;
          else dcmd = 1'b1;
        end
        MODE_LIFT: begin
          if (den) begin
            mode = MODE_IDLE;
          end else begin
            lcmd = lreq && stopped;
            if (ldone) begin
              lift_inh = 1'b1;
              mode     = MODE_IDLE;
            end else if (!lreq) begin
              mode = MODE_IDLE;
            end
          end
        end
        MODE_DUMP: begin
          if (den) begin
            mode = MODE_IDLE;
          end else begin
            ucmd = dreq && stopped;
            if (ddone) begin
              dump_inh = 1'b1;
              mode     = MODE_IDLE;
            end else if (!dreq) begin
              mode = MODE_IDLE;
            end
          end
        end
        MODE_FAULT: begin
          code = lcause;
          if (item.causes_clear && item.ack_pressed) begin
            latch  = 1'b0;
            lcause = CAUSE_NONE;
            mode   = MODE_IDLE;
          end
        end
        MODE_ESTOP: begin
          code = CAUSE_ESTOP;
          if (item.ack_pressed) mode = MODE_IDLE;
        end
        default: begin
          mode = MODE_IDLE;
          if (den && bat && cgood) begin
            mode = MODE_DRIVE;
          end else if (!lift_inh && lreq && !den && stopped) begin
            mode = MODE_LIFT;
            lcmd = 1'b1;
          end else if (!dump_inh && dreq && !den && stopped) begin
            mode = MODE_DUMP;
            ucmd = 1'b1;
          end
        end
      endcase
    end

    nxt.mode          = mode;
    nxt.fault_latch   = latch;
    nxt.latched_cause = lcause;
    nxt.lift_inhibit  = lift_inh;
    nxt.dump_inhibit  = dump_inh;
    nxt.comms         = comms_nxt;

    res.pad         = '0;
    res.comms_good  = cgood;
    res.fault_held  = latch;
    res.fault_id    = code;
    res.tip_on      = ucmd;
    res.hoist_on    = lcmd;
    res.traction_on = dcmd;
    res.mode        = mode;
  end

endmodule
`default_nettype wire
